>>> rtl/ljm_pkg.sv
// Package for the LCG skip-ahead matrix element generator.
// Holds shared types, register codes, LCG constants and the skip-ahead tables.
// No dependencies.
package ljm_pkg;

    // Register file limits and codes
    localparam logic [20:0] MAX_DIM  = 21'd1048576;
    localparam logic [10:0] MAX_TILE = 11'd1024;

    localparam logic [2:0] REG_SEED        = 3'd0;
    localparam logic [2:0] REG_TOTAL_ROWS  = 3'd1;
    localparam logic [2:0] REG_TOTAL_COLS  = 3'd2;
    localparam logic [2:0] REG_TILE_HEIGHT = 3'd3;
    localparam logic [2:0] REG_TILE_WIDTH  = 3'd4;

    localparam logic [63:0] RST_SEED        = 64'd100;
    localparam logic [20:0] RST_TOTAL_ROWS  = 21'd1024;
    localparam logic [20:0] RST_TOTAL_COLS  = 21'd1024;
    localparam logic [10:0] RST_TILE_HEIGHT = 11'd64;
    localparam logic [10:0] RST_TILE_WIDTH  = 11'd64;

    // LCG: x' = LCG_MUL * x + LCG_INC (mod 2^64)
    localparam logic [63:0] LCG_MUL  = 64'd6364136223846793005;
    localparam logic [63:0] LCG_INC  = 64'd1;
    localparam logic [31:0] HALF_FX  = 32'h8000_0000;

    typedef logic [63:0][63:0] t_tab;

    // Multiplier of the 2^k step jump: LCG_MUL^(2^k)
    function automatic t_tab f_make_a_tab();
        t_tab        tab;
        logic [63:0] a;
        a = LCG_MUL;
        for (int k = 0; k < 64; k++) begin
            tab[k] = a;
            a      = a * a;
        end
        return tab;
    endfunction

    // Increment of the 2^k step jump
    function automatic t_tab f_make_c_tab();
        t_tab        tab;
        logic [63:0] a;
        logic [63:0] c;
        a = LCG_MUL;
        c = LCG_INC;
        for (int k = 0; k < 64; k++) begin
            tab[k] = c;
            c      = c * (a + 64'd1);
            a      = a * a;
        end
        return tab;
    endfunction

    localparam t_tab LCG_A_TAB = f_make_a_tab();
    localparam t_tab LCG_C_TAB = f_make_c_tab();

    // Configuration seen by the sequencer
    typedef struct packed {
        logic [63:0] seed;
        logic [20:0] total_rows;
        logic [20:0] total_cols;
        logic [10:0] tile_height;
        logic [10:0] tile_width;
    } t_cfg;

    // Control of the shared multiply-accumulate unit
    typedef struct packed {
        logic en;       // update accumulator
        logic load;     // start from addend instead of accumulator
        logic shift32;  // add low product half into the upper word
    } t_mac_ctl;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROW,
        S_COL,
        S_CHK,
        S_OFF,
        S_BIT,
        S_M0,
        S_M1,
        S_M2,
        S_UPD,
        S_OUT
    } t_state;

endpackage

>>> rtl/ljm_cfg_regs.sv
// APB-style configuration register file with saturation on write.
// Depends on ljm_pkg.
module ljm_cfg_regs
    import ljm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[5:3];

    // Register writes, sizes clamp at their limits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seed        <= RST_SEED;
            r_cfg.total_rows  <= RST_TOTAL_ROWS;
            r_cfg.total_cols  <= RST_TOTAL_COLS;
            r_cfg.tile_height <= RST_TILE_HEIGHT;
            r_cfg.tile_width  <= RST_TILE_WIDTH;
        end else if (wr_en) begin
            case (idx)
                REG_SEED:        r_cfg.seed <= pwdata;
                REG_TOTAL_ROWS:  r_cfg.total_rows <= (pwdata[20:0] > MAX_DIM) ?
                                                     MAX_DIM : pwdata[20:0];
                REG_TOTAL_COLS:  r_cfg.total_cols <= (pwdata[20:0] > MAX_DIM) ?
                                                     MAX_DIM : pwdata[20:0];
                REG_TILE_HEIGHT: r_cfg.tile_height <= (pwdata[10:0] > MAX_TILE) ?
                                                      MAX_TILE : pwdata[10:0];
                REG_TILE_WIDTH:  r_cfg.tile_width <= (pwdata[10:0] > MAX_TILE) ?
                                                     MAX_TILE : pwdata[10:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (idx)
            REG_SEED:        prdata = r_cfg.seed;
            REG_TOTAL_ROWS:  prdata = {43'd0, r_cfg.total_rows};
            REG_TOTAL_COLS:  prdata = {43'd0, r_cfg.total_cols};
            REG_TILE_HEIGHT: prdata = {53'd0, r_cfg.tile_height};
            REG_TILE_WIDTH:  prdata = {53'd0, r_cfg.tile_width};
            default:         prdata = 64'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/ljm_mac.sv
// Shared 32x32 multiplier with a 64-bit accumulator register.
// Depends on ljm_pkg.
module ljm_mac
    import ljm_pkg::*;
(
    input  logic        i_clk,
    input  t_mac_ctl    i_ctl,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [63:0] i_add,
    output logic [63:0] o_acc
);

    logic [63:0] r_acc;
    logic [63:0] n_acc;
    logic [63:0] prod;
    logic [63:0] term;
    logic [63:0] base;

    // One partial product per cycle, optionally moved to the upper word
    always_comb begin
        prod  = {32'd0, i_a} * {32'd0, i_b};
        term  = i_ctl.shift32 ? {prod[31:0], 32'd0} : prod;
        base  = i_ctl.load ? i_add : r_acc;
        n_acc = base + term;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

>>> rtl/ljm_seq.sv
// Sequencer: coordinates, padding, binary skip-ahead loop and output register.
// Depends on ljm_pkg; drives the shared ljm_mac unit.
module ljm_seq
    import ljm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,
    input  logic        i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [87:0] o_m_tdata,
    output logic        o_m_tuser,
    output t_mac_ctl    o_mac_ctl,
    output logic [31:0] o_mac_a,
    output logic [31:0] o_mac_b,
    output logic [63:0] o_mac_add,
    input  logic [63:0] i_mac_acc
);

    // Control state
    t_state      r_state, n_state;
    logic        r_last, n_last;
    logic [5:0]  r_k, n_k;
    logic        r_ovalid, n_ovalid;

    // Payload
    logic        r_func, n_func;
    logic [19:0] r_trow, n_trow;
    logic [19:0] r_tcol, n_tcol;
    logic [9:0]  r_erow, n_erow;
    logic [9:0]  r_ecol, n_ecol;
    logic [30:0] r_r, n_r;
    logic [63:0] r_off, n_off;
    logic [63:0] r_x, n_x;
    logic [31:0] r_xre, n_xre;
    logic        r_pad, n_pad;
    logic        r_diag, n_diag;
    logic [53:0] r_ore, n_ore;
    logic [32:0] r_oim, n_oim;
    logic        r_opad, n_opad;

    // Helpers
    logic [10:0] th;
    logic [30:0] cc_glob;
    logic [30:0] lo_v, hi_v;
    logic        pad_v;
    logic [63:0] jmp_a, jmp_c;
    logic        out_load;
    logic [20:0] mx;

    assign th      = r_func ? i_cfg.tile_width : i_cfg.tile_height;
    assign cc_glob = i_mac_acc[30:0];
    assign jmp_a   = r_last ? LCG_MUL : LCG_A_TAB[r_k];
    assign jmp_c   = r_last ? LCG_INC : LCG_C_TAB[r_k];
    assign out_load = (r_state == S_OUT) && (!r_ovalid || i_m_tready);
    assign mx = (i_cfg.total_rows > i_cfg.total_cols) ? i_cfg.total_rows
                                                     : i_cfg.total_cols;

    // Padding test and mirror selection once both coordinates are known
    always_comb begin
        pad_v = ({1'b0, r_erow} >= th) || ({1'b0, r_ecol} >= i_cfg.tile_width)
              || (r_r >= {10'd0, i_cfg.total_rows})
              || (cc_glob >= {10'd0, i_cfg.total_cols});
        if (r_func && (r_r < cc_glob)) begin
            lo_v = cc_glob;
            hi_v = r_r;
        end else begin
            lo_v = r_r;
            hi_v = cc_glob;
        end
    end

    // Next state, datapath updates and multiplier operand selection
    always_comb begin
        n_state  = r_state;
        n_last   = r_last;
        n_k      = r_k;
        n_ovalid = r_ovalid;
        n_func   = r_func;
        n_trow   = r_trow;
        n_tcol   = r_tcol;
        n_erow   = r_erow;
        n_ecol   = r_ecol;
        n_r      = r_r;
        n_off    = r_off;
        n_x      = r_x;
        n_xre    = r_xre;
        n_pad    = r_pad;
        n_diag   = r_diag;
        n_ore    = r_ore;
        n_oim    = r_oim;
        n_opad   = r_opad;
        o_mac_ctl = '0;
        o_mac_a   = 32'd0;
        o_mac_b   = 32'd0;
        o_mac_add = 64'd0;

        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_func  = i_s_tuser;
                    n_trow  = i_s_tdata[19:0];
                    n_tcol  = i_s_tdata[39:20];
                    n_erow  = i_s_tdata[49:40];
                    n_ecol  = i_s_tdata[59:50];
                    n_state = S_ROW;
                end
            end
            // r = tile_row * th + elem_row
            S_ROW: begin
                o_mac_ctl = '{en: 1'b1, load: 1'b1, shift32: 1'b0};
                o_mac_a   = {12'd0, r_trow};
                o_mac_b   = {21'd0, th};
                o_mac_add = {54'd0, r_erow};
                n_state   = S_COL;
            end
            // c = tile_col * tile_width + elem_col
            S_COL: begin
                n_r       = i_mac_acc[30:0];
                o_mac_ctl = '{en: 1'b1, load: 1'b1, shift32: 1'b0};
                o_mac_a   = {12'd0, r_tcol};
                o_mac_b   = {21'd0, i_cfg.tile_width};
                o_mac_add = {54'd0, r_ecol};
                n_state   = S_CHK;
            end
            // Padding check; offset/2 = lo + hi * total_rows
            S_CHK: begin
                n_pad  = pad_v;
                n_diag = r_func && (r_r == cc_glob);
                n_x    = i_cfg.seed;
                if (pad_v) begin
                    n_state = S_OUT;
                end else begin
                    o_mac_ctl = '{en: 1'b1, load: 1'b1, shift32: 1'b0};
                    o_mac_a   = {1'b0, hi_v};
                    o_mac_b   = {11'd0, i_cfg.total_rows};
                    o_mac_add = {33'd0, lo_v};
                    n_state   = S_OFF;
                end
            end
            S_OFF: begin
                n_off   = {i_mac_acc[62:0], 1'b0};
                n_k     = 6'd0;
                n_last  = 1'b0;
                n_state = S_BIT;
            end
            // Walk the offset bits, jump where the bit is set
            S_BIT: begin
                if (r_off[r_k]) begin
                    n_state = S_M0;
                end else if (r_k == 6'd63) begin
                    n_xre   = r_x[63:32];
                    n_last  = 1'b1;
                    n_state = S_M0;
                end else begin
                    n_k = r_k + 6'd1;
                end
            end
            // x * a + c in three partial products
            S_M0: begin
                o_mac_ctl = '{en: 1'b1, load: 1'b1, shift32: 1'b0};
                o_mac_a   = jmp_a[31:0];
                o_mac_b   = r_x[31:0];
                o_mac_add = jmp_c;
                n_state   = S_M1;
            end
            S_M1: begin
                o_mac_ctl = '{en: 1'b1, load: 1'b0, shift32: 1'b1};
                o_mac_a   = jmp_a[63:32];
                o_mac_b   = r_x[31:0];
                n_state   = S_M2;
            end
            S_M2: begin
                o_mac_ctl = '{en: 1'b1, load: 1'b0, shift32: 1'b1};
                o_mac_a   = jmp_a[31:0];
                o_mac_b   = r_x[63:32];
                n_state   = S_UPD;
            end
            S_UPD: begin
                n_x = i_mac_acc;
                if (r_last) begin
                    n_state = S_OUT;
                end else if (r_k == 6'd63) begin
                    n_xre   = i_mac_acc[63:32];
                    n_last  = 1'b1;
                    n_state = S_M0;
                end else begin
                    n_k     = r_k + 6'd1;
                    n_state = S_BIT;
                end
            end
            // Form the result into the output register
            S_OUT: begin
                if (out_load) begin
                    n_ovalid = 1'b1;
                    n_opad   = r_pad;
                    if (r_pad) begin
                        n_ore = 54'd0;
                        n_oim = 33'd0;
                    end else begin
                        n_ore = ({22'd0, HALF_FX} - {22'd0, r_xre})
                              + (r_diag ? {1'b0, mx, 32'd0} : 54'd0);
                        n_oim = r_diag ? 33'd0
                                       : ({1'b0, HALF_FX} - {1'b0, r_x[63:32]});
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_last   <= 1'b0;
            r_k      <= 6'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_last   <= n_last;
            r_k      <= n_k;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_func <= n_func;
        r_trow <= n_trow;
        r_tcol <= n_tcol;
        r_erow <= n_erow;
        r_ecol <= n_ecol;
        r_r    <= n_r;
        r_off  <= n_off;
        r_x    <= n_x;
        r_xre  <= n_xre;
        r_pad  <= n_pad;
        r_diag <= n_diag;
        r_ore  <= n_ore;
        r_oim  <= n_oim;
        r_opad <= n_opad;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {1'b0, r_oim, r_ore};
    assign o_m_tuser  = r_opad;

    // The first partial product of a jump is always followed by the second
    a_mac_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_M0) |=> (r_state == S_M1))
        else $error("jump partial products out of order");

    // The bit walk never runs after the final LCG step was started
    a_walk_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BIT) |-> !r_last)
        else $error("bit walk with final step flag set");

    // A padded result carries zero data
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_opad) |-> ((r_ore == 54'd0) && (r_oim == 33'd0)))
        else $error("padded result with nonzero data");

    // A diagonal element has a zero imaginary part
    a_diag_imag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_diag) |=> (r_oim == 33'd0))
        else $error("diagonal element with nonzero imaginary part");

endmodule

>>> rtl/lcg_jump_matrix_element_gen.sv
// Top level of the LCG skip-ahead random matrix element generator.
// Depends on ljm_pkg, ljm_cfg_regs, ljm_mac and ljm_seq.
//
//  channel   direction  handshake               payload
//  s_axis    in         tvalid/tready           tdata: tile_row, tile_col, elem_row,
//                                               elem_col; tuser: func
//  m_axis    out        tvalid/tready           tdata: real_part, imag_part; tuser: padded
//  apb       in         psel/penable/pwrite     paddr/pwdata/prdata, 64-bit registers at 8*i
//
// An element taken from s_axis is worked through S_ROW, S_COL, S_CHK and S_OFF, then the
// bit walk over the jump offset, which has at most 40 set bits; each set bit and the final
// LCG step run S_M0, S_M1, S_M2 and S_UPD on the single shared 32x32 multiplier, and the
// result is formed in S_OUT; the next element is taken once the sequencer is back in idle.
// Reset is synchronous, active low; it clears the sequencer and loads register defaults.
// A padded element skips the walk and goes from S_CHK straight to S_OUT.
// Input is taken only when the sequencer is idle; a finished result waits in the
// output register while the next element is accepted and worked on.
module lcg_jump_matrix_element_gen
    import ljm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // tile_row[19:0], tile_col[39:20],
                                        // elem_row[49:40], elem_col[59:50], zero[63:60]
    input  logic        s_axis_tuser,   // func[0]
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // real_part[53:0], imag_part[86:54], zero[87]
    output logic        m_axis_tuser    // padded[0]
);

    t_cfg        cfg;
    t_mac_ctl    mac_ctl;
    logic [31:0] mac_a;
    logic [31:0] mac_b;
    logic [63:0] mac_add;
    logic [63:0] mac_acc;

    ljm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ljm_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (mac_ctl),
        .i_a   (mac_a),
        .i_b   (mac_b),
        .i_add (mac_add),
        .o_acc (mac_acc)
    );

    ljm_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser),
        .o_mac_ctl  (mac_ctl),
        .o_mac_a    (mac_a),
        .o_mac_b    (mac_b),
        .o_mac_add  (mac_add),
        .i_mac_acc  (mac_acc)
    );

endmodule
